>>> rtl/aat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aat_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 24;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int DT_BITS = 25;
   localparam int COEF_BITS = 32;
   localparam int PC_BITS = 7;

   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_SIZE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DELTA     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BETA      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EPSILON   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ZETA      = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAMMA     = 3'd6;

   localparam logic [DT_BITS-1:0]   RST_STEP_SIZE = 25'd335544;
   localparam logic [COEF_BITS-1:0] RST_DELTA     = 32'd58720256;
   localparam logic [COEF_BITS-1:0] RST_ALPHA     = 32'd15938355;
   localparam logic [COEF_BITS-1:0] RST_BETA      = 32'd11744051;
   localparam logic [COEF_BITS-1:0] RST_EPSILON   = 32'd4194304;
   localparam logic [COEF_BITS-1:0] RST_ZETA      = 32'd1677722;
   localparam logic [COEF_BITS-1:0] RST_GAMMA     = 32'd10066330;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2
   } alu_type;

   typedef enum logic [2:0] {
      JMP_NONE = 3'd0,
      JMP_GOTO = 3'd1,
      JMP_DISP = 3'd2,
      JMP_NOT2 = 3'd3,
      JMP_END  = 3'd4
   } jmp_type;

   // register file entries and state destinations
   localparam logic [3:0] R_PX = 4'd0;
   localparam logic [3:0] R_PY = 4'd1;
   localparam logic [3:0] R_PZ = 4'd2;
   localparam logic [3:0] R_KX = 4'd3;
   localparam logic [3:0] R_KY = 4'd4;
   localparam logic [3:0] R_KZ = 4'd5;
   localparam logic [3:0] R_SX = 4'd6;
   localparam logic [3:0] R_SY = 4'd7;
   localparam logic [3:0] R_SZ = 4'd8;
   localparam logic [3:0] R_T0 = 4'd9;
   localparam logic [3:0] R_T1 = 4'd10;
   localparam logic [3:0] R_T2 = 4'd11;
   localparam logic [3:0] R_T3 = 4'd12;
   localparam logic [3:0] D_X  = 4'd13;
   localparam logic [3:0] D_Y  = 4'd14;
   localparam logic [3:0] D_Z  = 4'd15;

   // operand sources beyond the register file
   localparam logic [4:0] S_X     = 5'd13;
   localparam logic [4:0] S_Y     = 5'd14;
   localparam logic [4:0] S_Z     = 5'd15;
   localparam logic [4:0] S_DT    = 5'd16;
   localparam logic [4:0] S_DELTA = 5'd17;
   localparam logic [4:0] S_ALPHA = 5'd18;
   localparam logic [4:0] S_BETA  = 5'd19;
   localparam logic [4:0] S_EPS   = 5'd20;
   localparam logic [4:0] S_ZETA  = 5'd21;
   localparam logic [4:0] S_GAMMA = 5'd22;
   localparam logic [4:0] S_ONE   = 5'd23;
   localparam logic [4:0] S_HALF  = 5'd24;
   localparam logic [4:0] S_THIRD = 5'd25;
   localparam logic [4:0] S_SIXTH = 5'd26;
   localparam logic [4:0] S_ZERO  = 5'd27;
   localparam logic [4:0] S_LX    = 5'd28;
   localparam logic [4:0] S_LY    = 5'd29;
   localparam logic [4:0] S_LZ    = 5'd30;

   localparam logic [PC_BITS-1:0] L_STEP  = 7'd0;
   localparam logic [PC_BITS-1:0] L_DERIV = 7'd3;
   localparam logic [PC_BITS-1:0] L_A     = 7'd27;
   localparam logic [PC_BITS-1:0] L_HALFP = 7'd30;
   localparam logic [PC_BITS-1:0] L_B     = 7'd39;
   localparam logic [PC_BITS-1:0] L_C     = 7'd51;
   localparam logic [PC_BITS-1:0] L_LOAD  = 7'd63;

   typedef struct packed {
      alu_type              alu;
      logic [3:0]           dst;
      logic [4:0]           src_a;
      logic [4:0]           src_b;
      jmp_type              jmp;
      logic [PC_BITS-1:0]   target;
      logic                 inc_stage;
   } cw_type;

   typedef struct packed {
      logic   start;
      logic   rd;
      logic   wr;
      cw_type cw;
   } ctrl_type;

   function automatic cw_type mk(alu_type alu, logic [3:0] dst, logic [4:0] a,
                                 logic [4:0] b, jmp_type jmp,
                                 logic [PC_BITS-1:0] target, logic inc);
      cw_type w;
      w.alu = alu;
      w.dst = dst;
      w.src_a = a;
      w.src_b = b;
      w.jmp = jmp;
      w.target = target;
      w.inc_stage = inc;
      return w;
   endfunction

   function automatic logic [4:0] rs(logic [3:0] r);
      return {1'b0, r};
   endfunction

   function automatic logic [PC_BITS-1:0] dispatch(logic [1:0] stage);
      logic [PC_BITS-1:0] t;
      case (stage)
         2'd0: t = L_A;
         2'd1: t = L_B;
         2'd2: t = L_B;
         default: t = L_C;
      endcase
      return t;
   endfunction

   function automatic cw_type rom(logic [PC_BITS-1:0] pc);
      cw_type w;
      case (pc)
         // step entry: copy state into probe point
         7'd0:  w = mk(ALU_ADD, R_PX, S_X, S_ZERO, JMP_NONE, L_STEP, 1'b0);
         7'd1:  w = mk(ALU_ADD, R_PY, S_Y, S_ZERO, JMP_NONE, L_STEP, 1'b0);
         7'd2:  w = mk(ALU_ADD, R_PZ, S_Z, S_ZERO, JMP_NONE, L_STEP, 1'b0);
         // derivative at probe point
         7'd3:  w = mk(ALU_SUB, R_T0, rs(R_PZ), S_BETA, JMP_NONE, L_STEP, 1'b0);
         7'd4:  w = mk(ALU_MUL, R_T1, rs(R_T0), rs(R_PX), JMP_NONE, L_STEP, 1'b0);
         7'd5:  w = mk(ALU_MUL, R_T2, S_DELTA, rs(R_PY), JMP_NONE, L_STEP, 1'b0);
         7'd6:  w = mk(ALU_SUB, R_KX, rs(R_T1), rs(R_T2), JMP_NONE, L_STEP, 1'b0);
         7'd7:  w = mk(ALU_MUL, R_T1, rs(R_T0), rs(R_PY), JMP_NONE, L_STEP, 1'b0);
         7'd8:  w = mk(ALU_MUL, R_T2, S_DELTA, rs(R_PX), JMP_NONE, L_STEP, 1'b0);
         7'd9:  w = mk(ALU_ADD, R_KY, rs(R_T1), rs(R_T2), JMP_NONE, L_STEP, 1'b0);
         7'd10: w = mk(ALU_MUL, R_T0, rs(R_PX), rs(R_PX), JMP_NONE, L_STEP, 1'b0);
         7'd11: w = mk(ALU_MUL, R_T1, rs(R_PY), rs(R_PY), JMP_NONE, L_STEP, 1'b0);
         7'd12: w = mk(ALU_MUL, R_T2, rs(R_PZ), rs(R_PZ), JMP_NONE, L_STEP, 1'b0);
         7'd13: w = mk(ALU_MUL, R_T2, rs(R_T2), rs(R_PZ), JMP_NONE, L_STEP, 1'b0);
         7'd14: w = mk(ALU_MUL, R_T2, rs(R_T2), S_THIRD, JMP_NONE, L_STEP, 1'b0);
         7'd15: w = mk(ALU_MUL, R_T3, S_ALPHA, rs(R_PZ), JMP_NONE, L_STEP, 1'b0);
         7'd16: w = mk(ALU_ADD, R_T3, S_GAMMA, rs(R_T3), JMP_NONE, L_STEP, 1'b0);
         7'd17: w = mk(ALU_SUB, R_T3, rs(R_T3), rs(R_T2), JMP_NONE, L_STEP, 1'b0);
         7'd18: w = mk(ALU_ADD, R_T1, rs(R_T0), rs(R_T1), JMP_NONE, L_STEP, 1'b0);
         7'd19: w = mk(ALU_MUL, R_T2, S_EPS, rs(R_PZ), JMP_NONE, L_STEP, 1'b0);
         7'd20: w = mk(ALU_ADD, R_T2, S_ONE, rs(R_T2), JMP_NONE, L_STEP, 1'b0);
         7'd21: w = mk(ALU_MUL, R_T1, rs(R_T1), rs(R_T2), JMP_NONE, L_STEP, 1'b0);
         7'd22: w = mk(ALU_SUB, R_T3, rs(R_T3), rs(R_T1), JMP_NONE, L_STEP, 1'b0);
         7'd23: w = mk(ALU_MUL, R_T1, S_ZETA, rs(R_PZ), JMP_NONE, L_STEP, 1'b0);
         7'd24: w = mk(ALU_MUL, R_T0, rs(R_T0), rs(R_PX), JMP_NONE, L_STEP, 1'b0);
         7'd25: w = mk(ALU_MUL, R_T0, rs(R_T1), rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd26: w = mk(ALU_ADD, R_KZ, rs(R_T3), rs(R_T0), JMP_DISP, L_STEP, 1'b0);
         // first stage: start sums
         7'd27: w = mk(ALU_ADD, R_SX, rs(R_KX), S_ZERO, JMP_NONE, L_STEP, 1'b0);
         7'd28: w = mk(ALU_ADD, R_SY, rs(R_KY), S_ZERO, JMP_NONE, L_STEP, 1'b0);
         7'd29: w = mk(ALU_ADD, R_SZ, rs(R_KZ), S_ZERO, JMP_NONE, L_STEP, 1'b0);
         // half step probe
         7'd30: w = mk(ALU_MUL, R_T0, rs(R_KX), S_DT, JMP_NONE, L_STEP, 1'b0);
         7'd31: w = mk(ALU_MUL, R_T0, rs(R_T0), S_HALF, JMP_NONE, L_STEP, 1'b0);
         7'd32: w = mk(ALU_ADD, R_PX, S_X, rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd33: w = mk(ALU_MUL, R_T0, rs(R_KY), S_DT, JMP_NONE, L_STEP, 1'b0);
         7'd34: w = mk(ALU_MUL, R_T0, rs(R_T0), S_HALF, JMP_NONE, L_STEP, 1'b0);
         7'd35: w = mk(ALU_ADD, R_PY, S_Y, rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd36: w = mk(ALU_MUL, R_T0, rs(R_KZ), S_DT, JMP_NONE, L_STEP, 1'b0);
         7'd37: w = mk(ALU_MUL, R_T0, rs(R_T0), S_HALF, JMP_NONE, L_STEP, 1'b0);
         7'd38: w = mk(ALU_ADD, R_PZ, S_Z, rs(R_T0), JMP_GOTO, L_DERIV, 1'b1);
         // middle stages: add twice k
         7'd39: w = mk(ALU_ADD, R_T0, rs(R_KX), rs(R_KX), JMP_NONE, L_STEP, 1'b0);
         7'd40: w = mk(ALU_ADD, R_SX, rs(R_SX), rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd41: w = mk(ALU_ADD, R_T0, rs(R_KY), rs(R_KY), JMP_NONE, L_STEP, 1'b0);
         7'd42: w = mk(ALU_ADD, R_SY, rs(R_SY), rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd43: w = mk(ALU_ADD, R_T0, rs(R_KZ), rs(R_KZ), JMP_NONE, L_STEP, 1'b0);
         7'd44: w = mk(ALU_ADD, R_SZ, rs(R_SZ), rs(R_T0), JMP_NOT2, L_HALFP, 1'b0);
         // full step probe
         7'd45: w = mk(ALU_MUL, R_T0, rs(R_KX), S_DT, JMP_NONE, L_STEP, 1'b0);
         7'd46: w = mk(ALU_ADD, R_PX, S_X, rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd47: w = mk(ALU_MUL, R_T0, rs(R_KY), S_DT, JMP_NONE, L_STEP, 1'b0);
         7'd48: w = mk(ALU_ADD, R_PY, S_Y, rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd49: w = mk(ALU_MUL, R_T0, rs(R_KZ), S_DT, JMP_NONE, L_STEP, 1'b0);
         7'd50: w = mk(ALU_ADD, R_PZ, S_Z, rs(R_T0), JMP_GOTO, L_DERIV, 1'b1);
         // last stage and update
         7'd51: w = mk(ALU_ADD, R_SX, rs(R_SX), rs(R_KX), JMP_NONE, L_STEP, 1'b0);
         7'd52: w = mk(ALU_ADD, R_SY, rs(R_SY), rs(R_KY), JMP_NONE, L_STEP, 1'b0);
         7'd53: w = mk(ALU_ADD, R_SZ, rs(R_SZ), rs(R_KZ), JMP_NONE, L_STEP, 1'b0);
         7'd54: w = mk(ALU_MUL, R_T0, S_DT, rs(R_SX), JMP_NONE, L_STEP, 1'b0);
         7'd55: w = mk(ALU_MUL, R_T0, rs(R_T0), S_SIXTH, JMP_NONE, L_STEP, 1'b0);
         7'd56: w = mk(ALU_ADD, D_X, S_X, rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd57: w = mk(ALU_MUL, R_T0, S_DT, rs(R_SY), JMP_NONE, L_STEP, 1'b0);
         7'd58: w = mk(ALU_MUL, R_T0, rs(R_T0), S_SIXTH, JMP_NONE, L_STEP, 1'b0);
         7'd59: w = mk(ALU_ADD, D_Y, S_Y, rs(R_T0), JMP_NONE, L_STEP, 1'b0);
         7'd60: w = mk(ALU_MUL, R_T0, S_DT, rs(R_SZ), JMP_NONE, L_STEP, 1'b0);
         7'd61: w = mk(ALU_MUL, R_T0, rs(R_T0), S_SIXTH, JMP_NONE, L_STEP, 1'b0);
         7'd62: w = mk(ALU_ADD, D_Z, S_Z, rs(R_T0), JMP_END, L_STEP, 1'b0);
         // load
         7'd63: w = mk(ALU_ADD, D_X, S_LX, S_ZERO, JMP_NONE, L_STEP, 1'b0);
         7'd64: w = mk(ALU_ADD, D_Y, S_LY, S_ZERO, JMP_NONE, L_STEP, 1'b0);
         7'd65: w = mk(ALU_ADD, D_Z, S_LZ, S_ZERO, JMP_END, L_STEP, 1'b0);
         default: w = mk(ALU_ADD, R_T3, S_ZERO, S_ZERO, JMP_END, L_STEP, 1'b0);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> rtl/aat_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module aat_seq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             op,
   output aat_pkg::ctrl_type     ctrl,
   output logic                  done
);

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'b001,
      SEQ_READ = 3'b010,
      SEQ_EXEC = 3'b100
   } seq_state_type;

   seq_state_type                 state_ff, state_in;
   logic [aat_pkg::PC_BITS-1:0]   pc_ff, pc_in;
   logic [1:0]                    stage_ff, stage_in;
   aat_pkg::cw_type               cw;

   assign cw = aat_pkg::rom(pc_ff);

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      stage_in = stage_ff;
      done = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_READ;
               pc_in = op ? aat_pkg::L_STEP : aat_pkg::L_LOAD;
               stage_in = 2'd0;
            end
         end
         SEQ_READ: begin
            state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            state_in = SEQ_READ;
            if (cw.inc_stage) begin
               stage_in = stage_ff + 2'd1;
            end
            case (cw.jmp)
               aat_pkg::JMP_GOTO: pc_in = cw.target;
               aat_pkg::JMP_DISP: pc_in = aat_pkg::dispatch(stage_ff);
               aat_pkg::JMP_NOT2: pc_in = (stage_ff != 2'd2) ? cw.target : pc_ff + 1'b1;
               aat_pkg::JMP_END: begin
                  state_in = SEQ_IDLE;
                  done = 1'b1;
               end
               default: pc_in = pc_ff + 1'b1;
            endcase
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff <= aat_pkg::L_STEP;
         stage_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         stage_ff <= stage_in;
      end
   end

   assign ctrl.start = start && (state_ff == SEQ_IDLE);
   assign ctrl.rd = (state_ff == SEQ_READ);
   assign ctrl.wr = (state_ff == SEQ_EXEC);
   assign ctrl.cw = cw;

endmodule
`default_nettype wire

>>> rtl/aat_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module aat_dp #(
   parameter int WORD_BITS = aat_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [aat_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [aat_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire aat_pkg::ctrl_type                   ctrl,
   input  wire logic signed [31:0]                  load_x,
   input  wire logic signed [31:0]                  load_y,
   input  wire logic signed [31:0]                  load_z,
   output logic signed [WORD_BITS-1:0]              x_state,
   output logic signed [WORD_BITS-1:0]              y_state,
   output logic signed [WORD_BITS-1:0]              z_state,
   output logic                                     overflow
);

   localparam int W = WORD_BITS;
   localparam int EW = ((W > 32) ? W : 32) + 2;
   localparam int PW = 2 * W;
   localparam logic [PW-1:0] ONE_W = PW'(1) << FRAC_BITS;
   localparam logic signed [W-1:0] C_ONE = W'(ONE_W);
   localparam logic signed [W-1:0] C_HALF = W'(ONE_W / 2);
   localparam logic signed [W-1:0] C_THIRD = W'((2 * ONE_W + 3) / 6);
   localparam logic signed [W-1:0] C_SIXTH = W'((ONE_W + 3) / 6);
   localparam logic signed [W-1:0] RST_XY = W'((ONE_W + 5) / 10);
   localparam logic signed [W-1:0] RST_Z = W'((ONE_W * 8 + 50) / 100);

   logic [aat_pkg::DT_BITS-1:0]    dt_ff;
   logic [aat_pkg::COEF_BITS-1:0]  delta_ff, alpha_ff, beta_ff, eps_ff, zeta_ff, gamma_ff;
   logic signed [31:0]             lx_ff, ly_ff, lz_ff;
   logic signed [W-1:0]            x_ff, y_ff, z_ff;
   logic                           ovf_ff;
   logic signed [W-1:0]            rf_mem [16];
   logic signed [W-1:0]            rda_ff, rdb_ff;
   logic signed [EW-1:0]           opa, opb;
   logic signed [EW:0]             sum;
   logic signed [PW-1:0]           prod, prod_sh;
   logic signed [W-1:0]            res;
   logic                           res_ovf;

   function automatic logic signed [EW-1:0] pick(logic [4:0] src,
                                                  logic signed [W-1:0] rd);
      logic signed [EW-1:0] v;
      case (src)
         aat_pkg::S_X:     v = EW'(x_ff);
         aat_pkg::S_Y:     v = EW'(y_ff);
         aat_pkg::S_Z:     v = EW'(z_ff);
         aat_pkg::S_DT:    v = EW'(signed'(W'({1'b0, dt_ff})));
         aat_pkg::S_DELTA: v = EW'(signed'(W'(signed'(delta_ff))));
         aat_pkg::S_ALPHA: v = EW'(signed'(W'(signed'(alpha_ff))));
         aat_pkg::S_BETA:  v = EW'(signed'(W'(signed'(beta_ff))));
         aat_pkg::S_EPS:   v = EW'(signed'(W'(signed'(eps_ff))));
         aat_pkg::S_ZETA:  v = EW'(signed'(W'(signed'(zeta_ff))));
         aat_pkg::S_GAMMA: v = EW'(signed'(W'(signed'(gamma_ff))));
         aat_pkg::S_ONE:   v = EW'(C_ONE);
         aat_pkg::S_HALF:  v = EW'(C_HALF);
         aat_pkg::S_THIRD: v = EW'(C_THIRD);
         aat_pkg::S_SIXTH: v = EW'(C_SIXTH);
         aat_pkg::S_ZERO:  v = '0;
         aat_pkg::S_LX:    v = EW'(lx_ff);
         aat_pkg::S_LY:    v = EW'(ly_ff);
         aat_pkg::S_LZ:    v = EW'(lz_ff);
         default:          v = EW'(rd);
      endcase
      return v;
   endfunction

   always_comb begin
      opa = pick(ctrl.cw.src_a, rda_ff);
      opb = pick(ctrl.cw.src_b, rdb_ff);
      prod = signed'(PW'(signed'(opa[W-1:0]))) * signed'(PW'(signed'(opb[W-1:0])));
      prod_sh = prod >>> FRAC_BITS;
      sum = (ctrl.cw.alu == aat_pkg::ALU_SUB) ? ((EW+1)'(opa) - (EW+1)'(opb))
                                               : ((EW+1)'(opa) + (EW+1)'(opb));
      res = '0;
      res_ovf = 1'b0;
      if (ctrl.cw.alu == aat_pkg::ALU_MUL) begin
         if (!(&prod_sh[PW-1:W-1]) && (|prod_sh[PW-1:W-1])) begin
            res_ovf = 1'b1;
            res = prod_sh[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            res = prod_sh[W-1:0];
         end
      end else begin
         if (!(&sum[EW:W-1]) && (|sum[EW:W-1])) begin
            res_ovf = 1'b1;
            res = sum[EW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            res = sum[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr && (ctrl.cw.dst < aat_pkg::D_X)) begin
         rf_mem[ctrl.cw.dst] <= res;
      end
      if (ctrl.rd) begin
         rda_ff <= rf_mem[ctrl.cw.src_a[3:0]];
         rdb_ff <= rf_mem[ctrl.cw.src_b[3:0]];
      end
      if (ctrl.start) begin
         lx_ff <= load_x;
         ly_ff <= load_y;
         lz_ff <= load_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= aat_pkg::RST_STEP_SIZE;
         delta_ff <= aat_pkg::RST_DELTA;
         alpha_ff <= aat_pkg::RST_ALPHA;
         beta_ff <= aat_pkg::RST_BETA;
         eps_ff <= aat_pkg::RST_EPSILON;
         zeta_ff <= aat_pkg::RST_ZETA;
         gamma_ff <= aat_pkg::RST_GAMMA;
         x_ff <= RST_XY;
         y_ff <= RST_XY;
         z_ff <= RST_Z;
         ovf_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               aat_pkg::CSR_STEP_SIZE: dt_ff <= csr_data[aat_pkg::DT_BITS-1:0];
               aat_pkg::CSR_DELTA:     delta_ff <= csr_data;
               aat_pkg::CSR_ALPHA:     alpha_ff <= csr_data;
               aat_pkg::CSR_BETA:      beta_ff <= csr_data;
               aat_pkg::CSR_EPSILON:   eps_ff <= csr_data;
               aat_pkg::CSR_ZETA:      zeta_ff <= csr_data;
               aat_pkg::CSR_GAMMA:     gamma_ff <= csr_data;
               default: ;
            endcase
         end
         if (ctrl.start) begin
            ovf_ff <= 1'b0;
         end else if (ctrl.wr) begin
            ovf_ff <= ovf_ff | res_ovf;
            case (ctrl.cw.dst)
               aat_pkg::D_X: x_ff <= res;
               aat_pkg::D_Y: y_ff <= res;
               aat_pkg::D_Z: z_ff <= res;
               default: ;
            endcase
         end
      end
   end

   assign x_state = x_ff;
   assign y_state = y_ff;
   assign z_state = z_ff;
   assign overflow = ovf_ff;

endmodule
`default_nettype wire

>>> rtl/aizawa_attractor_rk4_step.sv
// a load beat and a step beat each run as a sequence of microcode words,
// each word doing a register file read, then one alu op and write back
// throughput: one beat at a time; the next beat is accepted once the result is registered
// reset: synchronous, active high; restores coefficients, dt and state x=y=0.1, z=0.08
`timescale 1ns / 1ps
`default_nettype none
module aizawa_attractor_rk4_step #(
   parameter int WORD_BITS = aat_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [aat_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [aat_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_op,
   input  wire logic signed [31:0]                  req_load_x,
   input  wire logic signed [31:0]                  req_load_y,
   input  wire logic signed [31:0]                  req_load_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [31:0]                       rsp_x_out,
   output logic signed [31:0]                       rsp_y_out,
   output logic signed [31:0]                       rsp_z_out,
   output logic                                     rsp_overflow
);

   typedef enum logic [2:0] {
      TOP_IDLE = 3'b001,
      TOP_BUSY = 3'b010,
      TOP_HOLD = 3'b100
   } top_state_type;

   top_state_type               state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]          x_out_ff, y_out_ff, z_out_ff;
   logic                        ovf_out_ff;
   logic                        start, done, deliver;
   aat_pkg::ctrl_type           ctrl;
   logic signed [WORD_BITS-1:0] x_state, y_state, z_state;
   logic                        overflow;

   assign req_ready = (state_ff == TOP_IDLE);
   assign start = req_valid && req_ready;
   assign deliver = (state_ff == TOP_HOLD) && (!rsp_valid_ff || rsp_ready);

   aat_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_op),
      .ctrl  (ctrl),
      .done  (done)
   );

   aat_dp #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctrl      (ctrl),
      .load_x    (req_load_x),
      .load_y    (req_load_y),
      .load_z    (req_load_z),
      .x_state   (x_state),
      .y_state   (y_state),
      .z_state   (z_state),
      .overflow  (overflow)
   );

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         TOP_IDLE: if (start) state_in = TOP_BUSY;
         TOP_BUSY: if (done) state_in = TOP_HOLD;
         TOP_HOLD: begin
            if (deliver) begin
               state_in = TOP_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result beat registers
   always_ff @(posedge clock) begin
      if (deliver) begin
         x_out_ff <= 32'(x_state);
         y_out_ff <= 32'(y_state);
         z_out_ff <= 32'(z_state);
         ovf_out_ff <= overflow;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_out = x_out_ff;
   assign rsp_y_out = y_out_ff;
   assign rsp_z_out = z_out_ff;
   assign rsp_overflow = ovf_out_ff;

endmodule
`default_nettype wire
